/* hw/rtl/pcss_pkg.sv */
// ----------------------------------------------------------------------------
// pcss_pkg
// Shared types and codes for the per-class packet statistics block.
// ----------------------------------------------------------------------------
package pcss_pkg;

   localparam logic [2:0] KIND_PACKET = 3'd0;
   localparam logic [2:0] KIND_TICK   = 3'd1;
   localparam logic [2:0] KIND_QUERY  = 3'd2;
   localparam logic [2:0] KIND_GADD   = 3'd3;
   localparam logic [2:0] KIND_GREAD  = 3'd4;

   localparam int unsigned REQ_DATA_W = 72;
   localparam int unsigned RSP_DATA_W = 184;

   // Decoded item handed from the front to the back.
   typedef struct packed {
      logic        is_pkt;
      logic        is_tick;
      logic        is_query;
      logic        is_gadd;
      logic        is_gread;
      logic [5:0]  item;
      logic [15:0] bit_size;
      logic        reliable;
      logic [5:0]  rank;
      logic [9:0]  position;
      logic [31:0] delta;
   } op_type;

   // One class entry as held in the class stores.
   typedef struct packed {
      logic [47:0] bits;
      logic [31:0] unrel;
      logic [31:0] rel;
   } cls_type;

   // Result fields apart from the swap count.
   typedef struct packed {
      logic        error;
      logic [31:0] graph_value;
      logic [47:0] bit_sum;
      logic [31:0] unrel_count;
      logic [31:0] rel_count;
      logic [5:0]  item_index;
      logic        found;
   } res_type;

endpackage

/* hw/rtl/pcss_ram.sv */
// ----------------------------------------------------------------------------
// pcss_ram
// Single write port, single registered read port memory.
// ----------------------------------------------------------------------------
module pcss_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 1024,
   parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/pcss_front.sv */
// ----------------------------------------------------------------------------
// pcss_front
// Accepts request beats, decodes the kind and queues the decoded items.
// ----------------------------------------------------------------------------
module pcss_front (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [pcss_pkg::REQ_DATA_W-1:0]      req_tdata,
   input  logic [2:0]                           req_tuser,
   output logic                                 q_valid,
   input  logic                                 q_ready,
   output pcss_pkg::op_type                     q_op
);
   import pcss_pkg::*;

   op_type     dec;
   op_type     ent_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push, pop;

   always_comb begin
      dec          = '0;
      dec.item     = req_tdata[5:0];
      dec.bit_size = req_tdata[21:6];
      dec.reliable = req_tdata[22];
      dec.rank     = req_tdata[28:23];
      dec.position = req_tdata[38:29];
      dec.delta    = req_tdata[70:39];
      unique case (req_tuser)
         KIND_PACKET: dec.is_pkt   = 1'b1;
         KIND_TICK:   dec.is_tick  = 1'b1;
         KIND_QUERY:  dec.is_query = 1'b1;
         KIND_GADD:   dec.is_gadd  = 1'b1;
         KIND_GREAD:  dec.is_gread = 1'b1;
         default:     dec.is_pkt   = 1'b0;
      endcase
   end

   assign req_tready = (cnt_ff != 2'd2);
   assign push       = req_tvalid && req_tready;
   assign q_valid    = (cnt_ff != 2'd0);
   assign pop        = q_valid && q_ready;
   assign q_op       = ent_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         ent_ff[wr_ptr_ff] <= dec;
      end
   end

endmodule

/* hw/rtl/pcss_back.sv */
// ----------------------------------------------------------------------------
// pcss_back
// Executes decoded items against the gathered and shown stores.
// ----------------------------------------------------------------------------
module pcss_back #(
   parameter int unsigned NUM_CLASSES = 30,
   parameter int unsigned GRAPH_DEPTH = 1024
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic [15:0]                          interval,
   input  logic                                 q_valid,
   output logic                                 q_ready,
   input  pcss_pkg::op_type                     q_op,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [pcss_pkg::RSP_DATA_W-1:0]      rsp_tdata
);
   import pcss_pkg::*;

   localparam int unsigned CAW  = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
   localparam int unsigned GAW  = (GRAPH_DEPTH > 1) ? $clog2(GRAPH_DEPTH) : 1;
   localparam int unsigned MAXD = (NUM_CLASSES > GRAPH_DEPTH) ? NUM_CLASSES : GRAPH_DEPTH;
   localparam int unsigned CW   = $clog2(MAXD + 1);
   localparam logic [CW-1:0] NC_C   = CW'(NUM_CLASSES);
   localparam logic [CW-1:0] GD_C   = CW'(GRAPH_DEPTH);
   localparam logic [CW-1:0] LAST_C = CW'(MAXD - 1);

   typedef enum logic [5:0] {
      ST_CLEAR = 6'b000001,
      ST_IDLE  = 6'b000010,
      ST_EXEC  = 6'b000100,
      ST_COPY  = 6'b001000,
      ST_SCAN  = 6'b010000,
      ST_RESP  = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   op_type    op_ff, op_in;
   res_type   res_ff, res_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [CW-1:0] pipe_addr_ff, pipe_addr_in;
   logic          cp_vld_ff, cp_vld_in;
   logic          sc_vld_ff, sc_vld_in;
   logic [6:0]    used_ff, used_in;
   logic [15:0]   elapsed_ff, elapsed_in;
   logic [31:0]   swaps_ff, swaps_in;
   logic          out_vld_ff, out_vld_in;
   logic [RSP_DATA_W-1:0] out_ff, out_in;

   logic           gc_we, sc_we, gg_we, sg_we;
   logic [CAW-1:0] gc_waddr, gc_raddr, sc_waddr, sc_raddr;
   logic [GAW-1:0] gg_waddr, gg_raddr, sg_waddr, sg_raddr;
   cls_type        gc_wdata, gc_rdata, sc_wdata, sc_rdata;
   logic [31:0]    gg_wdata, gg_rdata, sg_wdata, sg_rdata;

   logic        cls_ok, pos_ok;
   logic [16:0] tick_next;
   cls_type     upd;

   pcss_ram #(.WIDTH($bits(cls_type)), .DEPTH(NUM_CLASSES)) u_gather_cls (
      .clock(clock), .wr_en(gc_we), .wr_addr(gc_waddr), .wr_data(gc_wdata),
      .rd_addr(gc_raddr), .rd_data(gc_rdata)
   );
   pcss_ram #(.WIDTH($bits(cls_type)), .DEPTH(NUM_CLASSES)) u_shown_cls (
      .clock(clock), .wr_en(sc_we), .wr_addr(sc_waddr), .wr_data(sc_wdata),
      .rd_addr(sc_raddr), .rd_data(sc_rdata)
   );
   pcss_ram #(.WIDTH(32), .DEPTH(GRAPH_DEPTH)) u_gather_graph (
      .clock(clock), .wr_en(gg_we), .wr_addr(gg_waddr), .wr_data(gg_wdata),
      .rd_addr(gg_raddr), .rd_data(gg_rdata)
   );
   pcss_ram #(.WIDTH(32), .DEPTH(GRAPH_DEPTH)) u_shown_graph (
      .clock(clock), .wr_en(sg_we), .wr_addr(sg_waddr), .wr_data(sg_wdata),
      .rd_addr(sg_raddr), .rd_data(sg_rdata)
   );

   assign cls_ok    = (7'(op_ff.item) < 7'(NUM_CLASSES));
   assign pos_ok    = (13'(op_ff.position) < 13'(GRAPH_DEPTH));
   assign tick_next = {1'b0, elapsed_ff} + 17'd1;
   assign q_ready   = (state_ff == ST_IDLE);

   always_comb begin
      upd       = gc_rdata;
      if (op_ff.reliable) begin
         upd.rel = gc_rdata.rel + 32'd1;
      end else begin
         upd.unrel = gc_rdata.unrel + 32'd1;
      end
      upd.bits = gc_rdata.bits + {32'd0, op_ff.bit_size};
   end

   // Read addresses: the sweep counter during a copy or scan, else the new item.
   always_comb begin
      gc_raddr = (state_ff == ST_COPY) ? cnt_ff[CAW-1:0] : CAW'(q_op.item);
      gg_raddr = (state_ff == ST_COPY) ? cnt_ff[GAW-1:0] : GAW'(q_op.position);
      sg_raddr = GAW'(q_op.position);
      sc_raddr = cnt_ff[CAW-1:0];
   end

   // Write ports: clearing pass, copy pipeline and item updates never overlap.
   always_comb begin
      gc_we    = 1'b0;
      gc_waddr = pipe_addr_ff[CAW-1:0];
      gc_wdata = '0;
      sc_we    = 1'b0;
      sc_waddr = pipe_addr_ff[CAW-1:0];
      sc_wdata = gc_rdata;
      gg_we    = 1'b0;
      gg_waddr = pipe_addr_ff[GAW-1:0];
      gg_wdata = '0;
      sg_we    = 1'b0;
      sg_waddr = pipe_addr_ff[GAW-1:0];
      sg_wdata = gg_rdata;
      if (state_ff == ST_CLEAR) begin
         gc_we    = (cnt_ff < NC_C);
         sc_we    = (cnt_ff < NC_C);
         gg_we    = (cnt_ff < GD_C);
         sg_we    = (cnt_ff < GD_C);
         gc_waddr = cnt_ff[CAW-1:0];
         sc_waddr = cnt_ff[CAW-1:0];
         gg_waddr = cnt_ff[GAW-1:0];
         sg_waddr = cnt_ff[GAW-1:0];
         sc_wdata = '0;
         sg_wdata = '0;
      end else if (cp_vld_ff) begin
         gc_we = (pipe_addr_ff < NC_C);
         sc_we = (pipe_addr_ff < NC_C);
         gg_we = (pipe_addr_ff < GD_C);
         sg_we = (pipe_addr_ff < GD_C);
      end else if (state_ff == ST_EXEC) begin
         gc_we    = op_ff.is_pkt && cls_ok;
         gc_waddr = CAW'(op_ff.item);
         gc_wdata = upd;
         gg_we    = op_ff.is_gadd && pos_ok;
         gg_waddr = GAW'(op_ff.position);
         gg_wdata = gg_rdata + op_ff.delta;
      end
   end

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      res_in       = res_ff;
      cnt_in       = cnt_ff;
      pipe_addr_in = pipe_addr_ff;
      cp_vld_in    = 1'b0;
      sc_vld_in    = 1'b0;
      used_in      = used_ff;
      elapsed_in   = elapsed_ff;
      swaps_in     = swaps_ff;
      out_vld_in   = out_vld_ff && !rsp_tready;
      out_in       = out_ff;

      unique case (state_ff)
         ST_CLEAR: begin
            cnt_in = cnt_ff + CW'(1);
            if (cnt_ff == LAST_C) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (q_valid) begin
               op_in    = q_op;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            res_in   = '0;
            state_in = ST_RESP;
            if (op_ff.is_pkt) begin
               res_in.error = !cls_ok;
            end
            if (op_ff.is_gread && pos_ok) begin
               res_in.graph_value = sg_rdata;
            end
            if (op_ff.is_tick) begin
               if (tick_next > {1'b0, interval}) begin
                  elapsed_in = '0;
                  swaps_in   = swaps_ff + 32'd1;
                  cnt_in     = '0;
                  state_in   = ST_COPY;
               end else begin
                  elapsed_in = tick_next[15:0];
               end
            end
            if (op_ff.is_query) begin
               cnt_in   = '0;
               used_in  = '0;
               state_in = ST_SCAN;
            end
         end
         ST_COPY: begin
            // Read gathered entry now, write shown and clear gathered next cycle.
            cp_vld_in    = 1'b1;
            pipe_addr_in = cnt_ff;
            cnt_in       = cnt_ff + CW'(1);
            if (cnt_ff == LAST_C) begin
               state_in = ST_RESP;
            end
         end
         ST_SCAN: begin
            if (sc_vld_ff && (sc_rdata.bits != 48'd0) && (used_ff[5:0] == op_ff.rank)) begin
               res_in.found       = 1'b1;
               res_in.item_index  = pipe_addr_ff[5:0];
               res_in.rel_count   = sc_rdata.rel;
               res_in.unrel_count = sc_rdata.unrel;
               res_in.bit_sum     = sc_rdata.bits;
               state_in           = ST_RESP;
            end else begin
               if (sc_vld_ff && (sc_rdata.bits != 48'd0)) begin
                  used_in = used_ff + 7'd1;
               end
               if (cnt_ff < NC_C) begin
                  sc_vld_in    = 1'b1;
                  pipe_addr_in = cnt_ff;
                  cnt_in       = cnt_ff + CW'(1);
               end else if (!sc_vld_ff) begin
                  state_in = ST_RESP;
               end
            end
         end
         ST_RESP: begin
            if (!out_vld_ff || rsp_tready) begin
               out_in     = {swaps_ff, res_ff};
               out_vld_in = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLEAR;
         cnt_ff     <= '0;
         cp_vld_ff  <= 1'b0;
         sc_vld_ff  <= 1'b0;
         elapsed_ff <= '0;
         swaps_ff   <= '0;
         out_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         cnt_ff     <= cnt_in;
         cp_vld_ff  <= cp_vld_in;
         sc_vld_ff  <= sc_vld_in;
         elapsed_ff <= elapsed_in;
         swaps_ff   <= swaps_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      res_ff       <= res_in;
      pipe_addr_ff <= pipe_addr_in;
      used_ff      <= used_in;
      out_ff       <= out_in;
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = out_ff;

endmodule

/* hw/rtl/packet_class_stats_snapshot.sv */
// ----------------------------------------------------------------------------
// packet_class_stats_snapshot
// Double-buffered per-class packet and graph statistics.
// ----------------------------------------------------------------------------
// Each request beat carries one item, its kind in req_tuser: packet, tick,
// stats query, graph add or graph read. Every item gives exactly one
// response beat, in order, carrying the swap count after the item.
// A two-beat queue sits between the decoding front and the executing back,
// and the response register lets a new item start while a result waits.
// Packet, graph, unknown and non-swapping tick items pass through the back's
// take, execute and respond states before the response register loads, and
// the back takes no new item before that. A stats query scans the shown
// class store one entry a cycle. A tick that swaps copies and clears the
// stores one entry a cycle. After reset a clearing pass runs before the
// first item is taken; the interval register returns to 1000. When the
// receiver stalls, one result is held in the response register, a second
// waits in the back and the queue fills, after which req_tready falls.
// ----------------------------------------------------------------------------
module packet_class_stats_snapshot #(
   parameter int unsigned NUM_CLASSES = 30,
   parameter int unsigned GRAPH_DEPTH = 1024
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // item[5:0], bit_size[21:6], reliable[22], rank[28:23], position[38:29],
   // delta[70:39], zero[71]
   input  logic [71:0]  req_tdata,
   // kind[2:0]
   input  logic [2:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // found[0], item_index[6:1], rel_count[38:7], unrel_count[70:39],
   // bit_sum[118:71], graph_value[150:119], swap_count[182:151], error[183]
   output logic [183:0] rsp_tdata,
   input  logic         csr_we,
   input  logic [15:0]  csr_wdata
);
   import pcss_pkg::*;

   logic [15:0] interval_ff;
   logic        q_valid, q_ready;
   op_type      q_op;
   logic [RSP_DATA_W-1:0] back_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         interval_ff <= 16'd1000;
      end else if (csr_we) begin
         interval_ff <= csr_wdata;
      end
   end

   pcss_front u_front (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .q_valid(q_valid), .q_ready(q_ready), .q_op(q_op)
   );

   pcss_back #(.NUM_CLASSES(NUM_CLASSES), .GRAPH_DEPTH(GRAPH_DEPTH)) u_back (
      .clock(clock), .reset(reset), .interval(interval_ff),
      .q_valid(q_valid), .q_ready(q_ready), .q_op(q_op),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(back_data)
   );

   // The back packs its result with the swap count above the other fields;
   // the error flag moves to the top so the fields follow the port layout.
   assign rsp_tdata = {back_data[151], back_data[RSP_DATA_W-1 -: 32], back_data[150:0]};

endmodule
